FILE: rtl/msic_pkg.sv
// ----------------------------------------------------------------------------
// msic_pkg
// Shared widths, sequencer states and control types of the merge sorter.
// ----------------------------------------------------------------------------
package msic_pkg;

  localparam int MAX_ITEMS_DEF = 64;
  localparam int DATA_W        = 32;
  localparam int INV_W         = 11;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_PASS_INIT,
    ST_RD,
    ST_CMP,
    ST_EMIT_RD,
    ST_EMIT_LAT,
    ST_EMIT_OUT
  } state_t;

  // control from the sequencer to the merge/count unit
  typedef struct packed {
    logic step;
    logic clear;
  } mrg_ctl_t;

endpackage

FILE: rtl/msic_if.sv
// ----------------------------------------------------------------------------
// msic_if
// Valid/ready channels for list elements in and sorted results out.
// ----------------------------------------------------------------------------
interface msic_in_if import msic_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] value;
  logic                     last;

  modport source (output valid, value, last, input ready);
  modport sink   (input valid, value, last, output ready);
endinterface

interface msic_out_if import msic_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] sorted_value;
  logic        [INV_W-1:0]  inversions;
  logic                     final_res;
  logic                     overflowed;

  modport source (output valid, sorted_value, inversions, final_res, overflowed,
                  input ready);
  modport sink   (input valid, sorted_value, inversions, final_res, overflowed,
                  output ready);
endinterface

FILE: rtl/msic_mem.sv
// ----------------------------------------------------------------------------
// msic_mem
// Element RAM: one write port, two registered read ports.
// ----------------------------------------------------------------------------
module msic_mem import msic_pkg::*; #(
  parameter int DEPTH = MAX_ITEMS_DEF,
  parameter int AW    = $clog2(MAX_ITEMS_DEF)
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [AW-1:0]            waddr,
  input  logic signed [DATA_W-1:0] wdata,
  input  logic [AW-1:0]            raddr_a,
  input  logic [AW-1:0]            raddr_b,
  output logic signed [DATA_W-1:0] rdata_a,
  output logic signed [DATA_W-1:0] rdata_b
);

  logic signed [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

FILE: rtl/msic_merge_unit.sv
// ----------------------------------------------------------------------------
// msic_merge_unit
// Picks the next element of a merge and accumulates the inversion total.
// ----------------------------------------------------------------------------
module msic_merge_unit import msic_pkg::*; #(
  parameter int CNT_W = $clog2(MAX_ITEMS_DEF + 1)
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  mrg_ctl_t                 ctl,
  input  logic signed [DATA_W-1:0] left_val,
  input  logic signed [DATA_W-1:0] right_val,
  input  logic                     left_avail,
  input  logic                     right_avail,
  input  logic [CNT_W-1:0]         left_rem,
  output logic                     take_right,
  output logic [INV_W-1:0]         total
);

  logic [INV_W-1:0] total_r, total_nxt;

  // ties go left to keep the sort stable and not count equal pairs
  assign take_right = !left_avail || (right_avail && (left_val > right_val));

  always_comb begin
    total_nxt = total_r;
    if (ctl.clear) begin
      total_nxt = '0;
    end else if (ctl.step && take_right) begin
      // every element still in the left run is greater than the one taken
      total_nxt = total_r + INV_W'(left_rem);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r <= '0;
    end else begin
      total_r <= total_nxt;
    end
  end

  assign total = total_r;

endmodule

FILE: rtl/merge_sort_inversion_count.sv
// ----------------------------------------------------------------------------
// merge_sort_inversion_count
// Stable bottom-up merge sort of a loaded list with inversion counting.
// ----------------------------------------------------------------------------
// Usage:
//   in_beat carries one signed element per beat; last marks the list end.
//   Elements past MAX_ITEMS are dropped and the results flag overflowed.
//   in_beat.ready is high only while the list is loading, one beat a cycle.
//   After the last beat the list of n stored elements is sorted by
//   ceil(log2 n) merge passes that ping-pong between two RAMs. Each pass
//   sets up its runs, then per element reads both run heads, then
//   compares and writes. Results then leave on out_beat, each through a
//   RAM read, a capture into the output register and the beat. A stall
//   holds the output register and the sequencer until out_beat.ready.
//   Every result carries the list's inversion total; final_res marks the
//   last one, after which count, drop flag and total are cleared.
//   Reset (rst_n low, synchronous) returns to loading an empty list; RAM
//   contents are not cleared, only written entries are ever used.
// ----------------------------------------------------------------------------
module merge_sort_inversion_count import msic_pkg::*; #(
  parameter int MAX_ITEMS = MAX_ITEMS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  msic_in_if.sink    in_beat,
  msic_out_if.source out_beat
);

  localparam int AW    = $clog2(MAX_ITEMS);
  localparam int CNT_W = $clog2(MAX_ITEMS + 1);
  localparam int XW    = CNT_W + 2;
  localparam logic [CNT_W-1:0] MAX_C = CNT_W'(MAX_ITEMS);
  localparam logic [CNT_W-1:0] ONE   = CNT_W'(1);

  state_t state_r, state_nxt;

  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             drop_r, drop_nxt;
  logic [CNT_W:0]   wid_r, wid_nxt;
  logic [CNT_W-1:0] i_r, i_nxt;
  logic [CNT_W-1:0] j_r, j_nxt;
  logic [CNT_W-1:0] mid_r, mid_nxt;
  logic [CNT_W-1:0] hi_r, hi_nxt;
  logic [CNT_W-1:0] k_r, k_nxt;
  logic [CNT_W-1:0] e_r, e_nxt;
  logic             src_r, src_nxt;

  logic signed [DATA_W-1:0] out_data_r, out_data_nxt;
  logic                     out_final_r, out_final_nxt;

  logic in_acc;
  logic store_ok;

  // RAM ports
  logic                     m0_we, m1_we;
  logic [AW-1:0]            m0_waddr, m1_waddr;
  logic signed [DATA_W-1:0] m0_wdata, m1_wdata;
  logic [AW-1:0]            raddr_a, raddr_b;
  logic signed [DATA_W-1:0] m0_rda, m0_rdb, m1_rda, m1_rdb;
  logic signed [DATA_W-1:0] rd_a, rd_b;

  // merge unit
  mrg_ctl_t         mctl;
  logic             left_avail, right_avail;
  logic             take_right;
  logic [INV_W-1:0] inv_total;
  logic signed [DATA_W-1:0] merged;

  // run bounds for the next pair of runs
  logic [XW-1:0] base_x, n_x, w_x, sum_mid, sum_hi;
  logic [CNT_W-1:0] mid_c, hi_c;
  logic run_end, pass_end;

  assign in_acc   = in_beat.valid && in_beat.ready;
  assign store_ok = (cnt_r != MAX_C);

  assign rd_a = src_r ? m1_rda : m0_rda;
  assign rd_b = src_r ? m1_rdb : m0_rdb;

  assign left_avail  = (i_r < mid_r);
  assign right_avail = (j_r < hi_r);
  assign merged      = take_right ? rd_b : rd_a;

  assign run_end  = ((k_r + ONE) == hi_r);
  assign pass_end = run_end && (hi_r == cnt_r);

  always_comb begin
    base_x  = (state_r == ST_PASS_INIT) ? '0 : XW'(hi_r);
    n_x     = XW'(cnt_r);
    w_x     = XW'(wid_r);
    sum_mid = base_x + w_x;
    sum_hi  = base_x + (w_x << 1);
    mid_c   = (sum_mid < n_x) ? sum_mid[CNT_W-1:0] : cnt_r;
    hi_c    = (sum_hi < n_x) ? sum_hi[CNT_W-1:0] : cnt_r;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_LOAD: begin
        if (in_acc && in_beat.last) begin
          state_nxt = ST_PASS_INIT;
        end
      end
      ST_PASS_INIT: begin
        if ({1'b0, cnt_r} <= wid_r) begin
          state_nxt = ST_EMIT_RD;
        end else begin
          state_nxt = ST_RD;
        end
      end
      ST_RD: state_nxt = ST_CMP;
      ST_CMP: begin
        if (pass_end) begin
          state_nxt = ST_PASS_INIT;
        end else begin
          state_nxt = ST_RD;
        end
      end
      ST_EMIT_RD:  state_nxt = ST_EMIT_LAT;
      ST_EMIT_LAT: state_nxt = ST_EMIT_OUT;
      ST_EMIT_OUT: begin
        if (out_beat.ready) begin
          state_nxt = out_final_r ? ST_LOAD : ST_EMIT_RD;
        end
      end
      default: state_nxt = ST_LOAD;
    endcase
  end

  // datapath registers
  always_comb begin
    cnt_nxt       = cnt_r;
    drop_nxt      = drop_r;
    wid_nxt       = wid_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    mid_nxt       = mid_r;
    hi_nxt        = hi_r;
    k_nxt         = k_r;
    e_nxt         = e_r;
    src_nxt       = src_r;
    out_data_nxt  = out_data_r;
    out_final_nxt = out_final_r;
    case (state_r)
      ST_LOAD: begin
        wid_nxt = (CNT_W + 1)'(1);
        src_nxt = 1'b0;
        if (in_acc) begin
          if (store_ok) begin
            cnt_nxt = cnt_r + ONE;
          end else begin
            drop_nxt = 1'b1;
          end
        end
      end
      ST_PASS_INIT: begin
        i_nxt   = '0;
        mid_nxt = mid_c;
        j_nxt   = mid_c;
        hi_nxt  = hi_c;
        k_nxt   = '0;
        e_nxt   = '0;
      end
      ST_CMP: begin
        if (take_right) begin
          j_nxt = j_r + ONE;
        end else begin
          i_nxt = i_r + ONE;
        end
        k_nxt = k_r + ONE;
        if (pass_end) begin
          src_nxt = !src_r;
          wid_nxt = wid_r << 1;
        end else if (run_end) begin
          i_nxt   = hi_r;
          mid_nxt = mid_c;
          j_nxt   = mid_c;
          hi_nxt  = hi_c;
        end
      end
      ST_EMIT_LAT: begin
        out_data_nxt  = rd_a;
        out_final_nxt = ((e_r + ONE) == cnt_r);
      end
      ST_EMIT_OUT: begin
        if (out_beat.ready) begin
          if (out_final_r) begin
            cnt_nxt  = '0;
            drop_nxt = 1'b0;
          end else begin
            e_nxt = e_r + ONE;
          end
        end
      end
      default: ;
    endcase
  end

  // RAM and merge-unit controls
  always_comb begin
    raddr_a = (state_r == ST_EMIT_RD) ? e_r[AW-1:0] : i_r[AW-1:0];
    raddr_b = j_r[AW-1:0];

    m0_we    = 1'b0;
    m0_waddr = k_r[AW-1:0];
    m0_wdata = merged;
    m1_we    = (state_r == ST_CMP) && !src_r;
    m1_waddr = k_r[AW-1:0];
    m1_wdata = merged;
    if (state_r == ST_LOAD) begin
      m0_we    = in_acc && store_ok;
      m0_waddr = cnt_r[AW-1:0];
      m0_wdata = in_beat.value;
    end else if (state_r == ST_CMP) begin
      m0_we = src_r;
    end

    mctl.step  = (state_r == ST_CMP);
    mctl.clear = (state_r == ST_EMIT_OUT) && out_beat.ready && out_final_r;
  end

  assign in_beat.ready         = (state_r == ST_LOAD);
  assign out_beat.valid        = (state_r == ST_EMIT_OUT);
  assign out_beat.sorted_value = out_data_r;
  assign out_beat.inversions   = inv_total;
  assign out_beat.final_res    = out_final_r;
  assign out_beat.overflowed   = drop_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
      cnt_r   <= '0;
      drop_r  <= 1'b0;
      wid_r   <= (CNT_W + 1)'(1);
      src_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      drop_r  <= drop_nxt;
      wid_r   <= wid_nxt;
      src_r   <= src_nxt;
    end
  end

  always_ff @(posedge clk) begin
    i_r         <= i_nxt;
    j_r         <= j_nxt;
    mid_r       <= mid_nxt;
    hi_r        <= hi_nxt;
    k_r         <= k_nxt;
    e_r         <= e_nxt;
    out_data_r  <= out_data_nxt;
    out_final_r <= out_final_nxt;
  end

  msic_mem #(.DEPTH(MAX_ITEMS), .AW(AW)) u_mem0 (
    .clk     (clk),
    .we      (m0_we),
    .waddr   (m0_waddr),
    .wdata   (m0_wdata),
    .raddr_a (raddr_a),
    .raddr_b (raddr_b),
    .rdata_a (m0_rda),
    .rdata_b (m0_rdb)
  );

  msic_mem #(.DEPTH(MAX_ITEMS), .AW(AW)) u_mem1 (
    .clk     (clk),
    .we      (m1_we),
    .waddr   (m1_waddr),
    .wdata   (m1_wdata),
    .raddr_a (raddr_a),
    .raddr_b (raddr_b),
    .rdata_a (m1_rda),
    .rdata_b (m1_rdb)
  );

  msic_merge_unit #(.CNT_W(CNT_W)) u_merge (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctl         (mctl),
    .left_val    (rd_a),
    .right_val   (rd_b),
    .left_avail  (left_avail),
    .right_avail (right_avail),
    .left_rem    (mid_r - i_r),
    .take_right  (take_right),
    .total       (inv_total)
  );

  // loading and emitting never overlap
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_beat.ready && out_beat.valid))
    else $error("input accepted while a result is pending");

  // a merge write always lands inside the current run with a head to take
  a_merge_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CMP) |-> ((k_r < hi_r) && (left_avail || right_avail)))
    else $error("merge step outside its run");

  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= MAX_C)
    else $error("item count beyond capacity");

  // per-list state is cleared once the final result is taken
  a_list_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (out_beat.valid && out_beat.ready && out_beat.final_res)
      |=> ((cnt_r == '0) && !drop_r && (inv_total == '0) && (state_r == ST_LOAD)))
    else $error("list state not cleared after final result");

endmodule

FILE: bench/tb_merge_sort_inversion_count.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_merge_sort_inversion_count
// Sends lists of signed elements and checks every sorted result, its
// inversion total, the end-of-list mark and the dropped-element flag.
// ----------------------------------------------------------------------------
module tb_merge_sort_inversion_count;
  import msic_pkg::*;

  localparam int CAPACITY = MAX_ITEMS_DEF;

  typedef struct {
    logic signed [DATA_W-1:0] sorted_value;
    logic        [INV_W-1:0]  inversions;
    logic                     final_res;
    logic                     overflowed;
  } sorted_beat_t;

  typedef enum int {VAL_FULL, VAL_NARROW, VAL_EXTREME} value_mix_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  msic_in_if  in_ch();
  msic_out_if out_ch();

  merge_sort_inversion_count #(.MAX_ITEMS(CAPACITY)) dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_beat (in_ch),
    .out_beat(out_ch)
  );

  always #5 clk = ~clk;

  // model state: elements of the list being loaded and results still owed
  logic signed [DATA_W-1:0] loading_list[$];
  bit                       loading_dropped;
  sorted_beat_t             sorted_backlog[$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_request  = 0;
  int hold_left     = 0;

  int error_count    = 0;
  int elements_sent  = 0;
  int results_seen   = 0;
  int lists_loaded   = 0;
  int lists_overflow = 0;

  function automatic void report_failure(input string msg);
    error_count++;
    if (error_count <= 10) $display("ERROR @%0t: %s", $time, msg);
  endfunction

  // Stores one accepted element; on the list end works out the sorted list
  // and its inversion total and queues one result per stored element.
  function automatic void load_element(input logic signed [DATA_W-1:0] v, input bit is_last);
    logic signed [DATA_W-1:0] ordered[$];
    logic signed [DATA_W-1:0] key;
    sorted_beat_t             r;
    int                       inv;
    int                       j;
    if (loading_list.size() < CAPACITY) loading_list.insert(loading_list.size(), v);
    else loading_dropped = 1'b1;
    if (!is_last) return;
    inv = 0;
    for (int a = 0; a < loading_list.size(); a++) begin
      for (int b = a + 1; b < loading_list.size(); b++) begin
        if (loading_list[a] > loading_list[b]) inv++;
      end
    end
    ordered = loading_list;
    for (int a = 1; a < ordered.size(); a++) begin
      key = ordered[a];
      j = a - 1;
      while (j >= 0 && ordered[j] > key) begin
        ordered[j + 1] = ordered[j];
        j--;
      end
      ordered[j + 1] = key;
    end
    for (int a = 0; a < ordered.size(); a++) begin
      r.sorted_value = ordered[a];
      r.inversions   = inv[INV_W-1:0];
      r.final_res    = (a == ordered.size() - 1);
      r.overflowed   = loading_dropped;
      sorted_backlog.insert(sorted_backlog.size(), r);
    end
    lists_loaded++;
    if (loading_dropped) lists_overflow++;
    loading_list.delete();
    loading_dropped = 1'b0;
  endfunction

  // Offers one element at a falling edge, holds it until the beat is taken.
  task automatic send_element(input logic signed [DATA_W-1:0] v, input bit is_last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.value <= v;
    in_ch.last  <= is_last;
    @(posedge clk);
    while (in_ch.ready !== 1'b1) @(posedge clk);
    load_element(v, is_last);
    elements_sent++;
    @(negedge clk);
  endtask

  // Stops offering and waits for every owed result.
  task automatic pause_until_drained();
    in_ch.valid <= 1'b0;
    do @(negedge clk); while (sorted_backlog.size() != 0);
  endtask

  function automatic logic signed [DATA_W-1:0] pick_value(input value_mix_t mix);
    int unsigned sel;
    case (mix)
      VAL_NARROW: return $signed($urandom_range(6)) - 3;
      VAL_EXTREME: begin
        sel = $urandom_range(4);
        case (sel)
          0: return 32'sh8000_0000;
          1: return 32'sh7fff_ffff;
          2: return 32'sh0000_0000;
          3: return -32'sd1;
          default: return 32'sd1;
        endcase
      end
      default: return $urandom;
    endcase
  endfunction

  task automatic send_list(input int len, input value_mix_t mix);
    for (int i = 0; i < len; i++) send_element(pick_value(mix), i == len - 1);
  endtask

  function automatic int pick_length();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 70) return $urandom_range(8, 1);
    if (r < 92) return $urandom_range(40, 9);
    if (r < 97) return $urandom_range(CAPACITY, 41);
    return $urandom_range(CAPACITY + 6, CAPACITY + 1);
  endfunction

  // Receiver: random stalls, or a long hold-off when one is requested.
  always @(negedge clk) begin
    if (hold_request > 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    sorted_beat_t want;
    if (rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      results_seen++;
      if (sorted_backlog.size() == 0) begin
        report_failure($sformatf("unexpected result value=%0d inv=%0d final=%b ovf=%b",
                                 out_ch.sorted_value, out_ch.inversions,
                                 out_ch.final_res, out_ch.overflowed));
      end else begin
        want = sorted_backlog.pop_front();
        if (out_ch.sorted_value !== want.sorted_value || out_ch.inversions !== want.inversions ||
            out_ch.final_res !== want.final_res || out_ch.overflowed !== want.overflowed) begin
          report_failure($sformatf(
              "exp value=%0d inv=%0d final=%b ovf=%b, got value=%0d inv=%0d final=%b ovf=%b",
              want.sorted_value, want.inversions, want.final_res, want.overflowed,
              out_ch.sorted_value, out_ch.inversions, out_ch.final_res, out_ch.overflowed));
        end
      end
    end
  end

  // single element, extremes, duplicates, sorted input, all equal, a swap
  task automatic test_directed();
    logic signed [DATA_W-1:0] mixed[8] = '{32'sd7, 32'sh8000_0000, 32'sh7fff_ffff, 32'sd0,
                                           -32'sd1, 32'sd7, 32'sd7, -32'sd1};
    send_element(32'sh7fff_ffff, 1'b1);
    foreach (mixed[i]) send_element(mixed[i], i == 7);
    send_element(-32'sd5, 1'b0);
    send_element(-32'sd3, 1'b0);
    send_element(32'sd0, 1'b0);
    send_element(32'sd4, 1'b1);
    for (int i = 0; i < 3; i++) send_element(32'sd3, i == 2);
    send_element(32'sd1, 1'b0);
    send_element(32'sd0, 1'b1);
    pause_until_drained();
  endtask

  // full store with the most inversions, then lists that spill past capacity, then a short list
  task automatic test_capacity();
    for (int i = 0; i < CAPACITY; i++) send_element(1000 - 37 * i, i == CAPACITY - 1);
    send_list(CAPACITY + 2, VAL_FULL);
    send_list(CAPACITY + 1, VAL_NARROW);
    send_element(32'sd2, 1'b0);
    send_element(32'sd1, 1'b1);
    pause_until_drained();
  endtask

  // receiver stalls for a long stretch while lists keep coming
  task automatic test_backpressure();
    hold_request = 400;
    for (int i = 0; i < 3; i++) send_list(12, VAL_FULL);
    pause_until_drained();
  endtask

  task automatic test_random(input int target);
    int start;
    int unsigned mix;
    start = elements_sent;
    while (elements_sent - start < target) begin
      mix = $urandom_range(9);
      send_list(pick_length(), mix < 6 ? VAL_FULL : (mix < 9 ? VAL_NARROW : VAL_EXTREME));
    end
    pause_until_drained();
  endtask

  initial begin
    in_ch.valid  = 1'b0;
    in_ch.value  = '0;
    in_ch.last   = 1'b0;
    out_ch.ready = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    send_idle_pct = 35;
    recv_idle_pct = 66;
    test_directed();
    test_capacity();
    test_random(90);

    send_idle_pct = 66;
    recv_idle_pct = 35;
    test_backpressure();
    test_random(90);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(70);

    repeat (100) @(posedge clk);
    if (sorted_backlog.size() != 0)
      report_failure($sformatf("%0d results never arrived", sorted_backlog.size()));
    $display("Summary: %0d lists (%0d past capacity), %0d elements sent, %0d results checked",
             lists_loaded, lists_overflow, elements_sent, results_seen);
    $display("Idling: sender/receiver at 35/66, 66/35 and 0/0 percent, one 400-cycle hold");
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("%0d failures", error_count);
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #(5_000_000);
    $display("Timeout with %0d results outstanding", sorted_backlog.size());
    $display("Verification failed");
    $finish;
  end

endmodule
